/* rtl/mrpa_pkg.sv */
`default_nettype none
package mrpa_pkg;

  localparam int WORD_W     = 64;
  localparam int ACTION_W   = 4;
  localparam int SEL_W      = 2;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Quotient bits resolved per divider stage.
  localparam int STEP_BITS = 4;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;
  localparam int                 RADIX_RESET = 2;

  localparam logic [ACTION_W-1:0] ACT_ADD     = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_SUB     = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_MUL     = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_DIV     = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_MOD     = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_NEG     = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_SUCC    = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_PRED    = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_PROJECT = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX0 = 3'd1;

endpackage
`default_nettype wire

/* rtl/mrpa_req_if.sv */
`default_nettype none
interface mrpa_req_if;
  import mrpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [WORD_W-1:0]   left;
  logic [WORD_W-1:0]   right;
  logic [SEL_W-1:0]    component_index;
  modport source(output valid, action, left, right, component_index, input ready);
  modport sink(input valid, action, left, right, component_index, output ready);
endinterface
`default_nettype wire

/* rtl/mrpa_rsp_if.sv */
`default_nettype none
interface mrpa_rsp_if;
  import mrpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result;
  logic              divide_by_zero;
  logic              left_less;
  logic              equal;
  modport source(output valid, result, divide_by_zero, left_less, equal, input ready);
  modport sink(input valid, result, divide_by_zero, left_less, equal, output ready);
endinterface
`default_nettype wire

/* rtl/mrpa_cfg_if.sv */
`default_nettype none
interface mrpa_cfg_if;
  import mrpa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/mrpa_divider.sv */
`default_nettype none
module mrpa_divider #(
  parameter int LANES = 2,
  parameter int NUM_W = 64,
  parameter int DEN_W = 16,
  parameter int TAG_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [NUM_W-1:0] num [LANES],
  input  wire logic [DEN_W-1:0] den [LANES],
  input  wire logic [TAG_W-1:0] tag,
  output logic                  out_valid,
  output logic [NUM_W-1:0]      quot [LANES],
  output logic [DEN_W-1:0]      rem [LANES],
  output logic [TAG_W-1:0]      out_tag
);
  import mrpa_pkg::*;

  localparam int STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W  = STAGES * STEP_BITS;

  logic             v     [STAGES];
  logic [PAD_W-1:0] n     [STAGES][LANES];
  logic [DEN_W-1:0] r     [STAGES][LANES];
  logic [DEN_W-1:0] d     [STAGES][LANES];
  logic [TAG_W-1:0] t     [STAGES];
  logic             v_src [STAGES];
  logic [PAD_W-1:0] n_src [STAGES][LANES];
  logic [DEN_W-1:0] r_src [STAGES][LANES];
  logic [DEN_W-1:0] d_src [STAGES][LANES];
  logic [TAG_W-1:0] t_src [STAGES];

  // Restoring division: the dividend shifts out at the top while the
  // quotient bits shift in at the bottom of the same register.
  function automatic logic [PAD_W+DEN_W-1:0] div_step(
    input logic [PAD_W-1:0] n_in,
    input logic [DEN_W-1:0] r_in,
    input logic [DEN_W-1:0] d_in
  );
    logic [PAD_W-1:0] nn;
    logic [DEN_W-1:0] rr;
    logic [DEN_W:0]   tmp;
    nn = n_in;
    rr = r_in;
    for (int b = 0; b < STEP_BITS; b++) begin
      tmp = {rr, nn[PAD_W-1]};
      nn  = {nn[PAD_W-2:0], 1'b0};
      if (tmp >= {1'b0, d_in}) begin
        tmp   = tmp - {1'b0, d_in};
        nn[0] = 1'b1;
      end
      rr = tmp[DEN_W-1:0];
    end
    return {nn, rr};
  endfunction

  for (genvar s = 0; s < STAGES; s++) begin : g_src
    if (s == 0) begin : g_first
      assign v_src[s] = in_valid;
      assign t_src[s] = tag;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign n_src[s][l] = PAD_W'(num[l]);
        assign r_src[s][l] = '0;
        assign d_src[s][l] = den[l];
      end
    end else begin : g_next
      assign v_src[s] = v[s-1];
      assign t_src[s] = t[s-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign n_src[s][l] = n[s-1][l];
        assign r_src[s][l] = r[s-1][l];
        assign d_src[s][l] = d[s-1][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) v[s] <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < STAGES; s++) v[s] <= v_src[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STAGES; s++) begin
        t[s] <= t_src[s];
        for (int l = 0; l < LANES; l++) begin
          {n[s][l], r[s][l]} <= div_step(n_src[s][l], r_src[s][l], d_src[s][l]);
          d[s][l] <= d_src[s][l];
        end
      end
    end
  end

  assign out_valid = v[STAGES-1];
  assign out_tag   = t[STAGES-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quot[l] = n[STAGES-1][l][NUM_W-1:0];
    assign rem[l]  = r[STAGES-1][l];
  end

endmodule
`default_nettype wire

/* rtl/mixed_radix_packed_arithmetic_core.sv */
// Throughput: one word per cycle unless the output is held; the chained long dividers
// that split both operands into digits, four quotient bits per stage, set the depth,
// and every stage takes a word per cycle.
// The whole pipe holds while the output register is full and not taken.
// Reset (synchronous, active high) empties the pipe and sets two components of radix 2.
`default_nettype none
module mixed_radix_packed_arithmetic_core #(
  parameter int MAX_COMPONENTS = 4,
  parameter int RADIX_BITS     = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mrpa_req_if.sink    req,
  mrpa_rsp_if.source  rsp,
  mrpa_cfg_if.sink    cfg
);
  import mrpa_pkg::*;

  localparam int MC  = MAX_COMPONENTS;
  localparam int RB  = RADIX_BITS;
  localparam int OPW = 2 * RB;
  localparam int NH  = (MC + 1) / 2;

  typedef logic [RB-1:0] digit_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SEL_W-1:0]    sel;
    logic                lt;
    logic                eq;
    logic [WORD_W-1:0]   left;
    logic [WORD_W-1:0]   right;
  } in_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SEL_W-1:0]    sel;
    logic                lt;
    logic                eq;
    digit_t [MC-1:0]     ldig;
    digit_t [MC-1:0]     rdig;
  } ext_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SEL_W-1:0]    sel;
    logic                lt;
    logic                eq;
    digit_t [MC-1:0]     lcomp;
    logic [MC-1:0]       bz;
  } opt_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                lt;
    logic                eq;
    logic                dz;
    digit_t              pv;
  } side_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                lt;
    logic                eq;
    logic                dz;
    logic [WORD_W-1:0]   result;
  } fin_t;

  // Configuration registers and the weights derived from them.
  logic [COUNT_W-1:0] cnt_reg;
  digit_t             radix_reg [MC];
  digit_t             radv [MC];
  logic [COUNT_W-1:0] kcnt;
  logic [WORD_W-1:0]  w_reg [MC];
  logic [WORD_W-1:0]  total_reg;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_reg <= COUNT_RESET;
      for (int i = 0; i < MC; i++) radix_reg[i] <= RB'(RADIX_RESET);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_COUNT: begin
          cnt_reg <= cfg.data[COUNT_W-1:0];
        end
        default: begin
          for (int i = 0; i < MC; i++) begin
            if (cfg.index == CFG_IDX_W'(int'(REG_RADIX0) + i)) radix_reg[i] <= cfg.data[RB-1:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MC; i++) radv[i] = (radix_reg[i] == '0) ? RB'(1) : radix_reg[i];
    if (cnt_reg == '0) kcnt = COUNT_W'(1);
    else if (int'(cnt_reg) > MC) kcnt = COUNT_W'(MC);
    else kcnt = cnt_reg;
  end

  // The weights settle through a registered chain, long before a word reaches them.
  for (genvar i = 0; i < MC; i++) begin : g_weight
    if (i == MC - 1) begin : g_last
      always_ff @(posedge clk) w_reg[i] <= WORD_W'(1);
    end else begin : g_chain
      always_ff @(posedge clk) begin
        if (i + 1 < int'(kcnt)) w_reg[i] <= WORD_W'(w_reg[i+1] * radv[i+1]);
        else w_reg[i] <= WORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) total_reg <= WORD_W'(w_reg[0] * radv[0]);

  // Pipeline control: every stage moves together unless the output is held.
  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Input stage.
  logic s0_v;
  in_t  s0;

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (en) s0_v <= req.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0.action <= req.action;
      s0.sel    <= req.component_index;
      s0.lt     <= req.left < req.right;
      s0.eq     <= req.left == req.right;
      s0.left   <= req.left;
      s0.right  <= req.right;
    end
  end

  // Digit extraction: round j divides by the radix of component k-1-j, so the
  // least significant digit falls out first.
  logic                     x_v    [MC];
  logic [WORD_W-1:0]        x_num  [MC][2];
  digit_t                   x_den  [MC][2];
  ext_t                     x_tag  [MC];
  logic                     y_v    [MC];
  logic [WORD_W-1:0]        y_quot [MC][2];
  digit_t                   y_rem  [MC][2];
  logic [$bits(ext_t)-1:0]  y_tag  [MC];
  ext_t                     z_tag  [MC];
  digit_t                   round_den [MC];

  function automatic ext_t put_digits(input ext_t t, input int j, input digit_t l,
                                      input digit_t r);
    ext_t o;
    o         = t;
    o.ldig[j] = l;
    o.rdig[j] = r;
    return o;
  endfunction

  always_comb begin
    for (int j = 0; j < MC; j++) begin
      round_den[j] = RB'(1);
      for (int i = 0; i < MC; i++) begin
        if (j < int'(kcnt) && i == int'(kcnt) - 1 - j) round_den[j] = radv[i];
      end
    end
  end

  for (genvar j = 0; j < MC; j++) begin : g_round
    if (j == 0) begin : g_first
      assign x_v[j]      = s0_v;
      assign x_num[j][0] = s0.left;
      assign x_num[j][1] = s0.right;
      assign x_tag[j]    = '{action: s0.action, sel: s0.sel, lt: s0.lt, eq: s0.eq,
                             ldig: '0, rdig: '0};
    end else begin : g_next
      assign x_v[j]      = y_v[j-1];
      assign x_num[j][0] = y_quot[j-1][0];
      assign x_num[j][1] = y_quot[j-1][1];
      assign x_tag[j]    = z_tag[j-1];
    end
    assign x_den[j][0] = round_den[j];
    assign x_den[j][1] = round_den[j];
    assign z_tag[j]    = put_digits(ext_t'(y_tag[j]), j, y_rem[j][0], y_rem[j][1]);

    mrpa_divider #(
      .LANES(2), .NUM_W(WORD_W), .DEN_W(RB), .TAG_W($bits(ext_t))
    ) u_ext (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(x_v[j]), .num(x_num[j]), .den(x_den[j]), .tag(x_tag[j]),
      .out_valid(y_v[j]), .quot(y_quot[j]), .rem(y_rem[j]), .out_tag(y_tag[j])
    );
  end

  // Operand forming: every componentwise action becomes one small division.
  ext_t             et;
  digit_t           fa [MC];
  digit_t           fb [MC];
  logic [OPW-1:0]   f_num [MC];
  digit_t           f_den [MC];
  logic [MC-1:0]    f_bz;
  logic             fm_v;
  opt_t             fm_tag;
  logic [OPW-1:0]   fm_num [MC];
  digit_t           fm_den [MC];

  assign et = z_tag[MC-1];

  always_comb begin
    for (int i = 0; i < MC; i++) begin
      fa[i] = '0;
      fb[i] = '0;
      for (int j = 0; j < MC; j++) begin
        if (i < int'(kcnt) && j == int'(kcnt) - 1 - i) begin
          fa[i] = et.ldig[j];
          fb[i] = et.rdig[j];
        end
      end
      f_bz[i]  = fb[i] == '0;
      f_den[i] = radv[i];
      case (et.action)
        ACT_ADD: f_num[i] = OPW'(fa[i]) + OPW'(fb[i]);
        ACT_SUB: f_num[i] = OPW'(fa[i]) + OPW'(radv[i]) - OPW'(fb[i]);
        ACT_MUL: f_num[i] = OPW'(fa[i]) * OPW'(fb[i]);
        ACT_DIV, ACT_MOD: begin
          f_num[i] = OPW'(fa[i]);
          f_den[i] = fb[i];
        end
        ACT_NEG: f_num[i] = OPW'(radv[i]) - OPW'(fa[i]);
        default: f_num[i] = OPW'(fa[i]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) fm_v <= 1'b0;
    else if (en) fm_v <= y_v[MC-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fm_tag.action <= et.action;
      fm_tag.sel    <= et.sel;
      fm_tag.lt     <= et.lt;
      fm_tag.eq     <= et.eq;
      fm_tag.bz     <= f_bz;
      for (int i = 0; i < MC; i++) begin
        fm_tag.lcomp[i] <= fa[i];
        fm_num[i]       <= f_num[i];
        fm_den[i]       <= f_den[i];
      end
    end
  end

  // Componentwise division.
  logic                    o_v;
  logic [OPW-1:0]          o_quot [MC];
  digit_t                  o_rem  [MC];
  logic [$bits(opt_t)-1:0] o_tag_raw;
  opt_t                    ot;

  mrpa_divider #(
    .LANES(MC), .NUM_W(OPW), .DEN_W(RB), .TAG_W($bits(opt_t))
  ) u_op (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(fm_v), .num(fm_num), .den(fm_den), .tag(fm_tag),
    .out_valid(o_v), .quot(o_quot), .rem(o_rem), .out_tag(o_tag_raw)
  );

  assign ot = opt_t'(o_tag_raw);

  // Component select.
  digit_t c_next [MC];
  side_t  sd_next;
  logic   sl_v;
  side_t  sl;
  digit_t sl_c [MC];

  always_comb begin
    sd_next.action = ot.action;
    sd_next.lt     = ot.lt;
    sd_next.eq     = ot.eq;
    sd_next.dz     = 1'b0;
    sd_next.pv     = '0;
    for (int i = 0; i < MC; i++) begin
      c_next[i] = '0;
      if (i < int'(kcnt)) begin
        case (ot.action)
          ACT_ADD, ACT_SUB, ACT_MUL, ACT_NEG: c_next[i] = o_rem[i];
          ACT_DIV: begin
            c_next[i] = ot.bz[i] ? '0 : o_quot[i][RB-1:0];
            if (ot.bz[i]) sd_next.dz = 1'b1;
          end
          ACT_MOD: begin
            c_next[i] = ot.bz[i] ? '0 : o_rem[i];
            if (ot.bz[i]) sd_next.dz = 1'b1;
          end
          ACT_SUCC, ACT_PRED: c_next[i] = ot.lcomp[i];
          default: c_next[i] = '0;
        endcase
        if (i == int'(ot.sel)) sd_next.pv = ot.lcomp[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sl_v <= 1'b0;
    else if (en) sl_v <= o_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl <= sd_next;
      for (int i = 0; i < MC; i++) sl_c[i] <= c_next[i];
    end
  end

  // Weighting.
  logic              mu_v;
  side_t             mu;
  logic [WORD_W-1:0] mu_p [MC];

  always_ff @(posedge clk) begin
    if (rst) mu_v <= 1'b0;
    else if (en) mu_v <= sl_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu <= sl;
      for (int i = 0; i < MC; i++) mu_p[i] <= WORD_W'(sl_c[i] * w_reg[i]);
    end
  end

  // Sum of the weighted components in two levels.
  logic [WORD_W-1:0] h_next [NH];
  logic              hs_v;
  side_t             hs;
  logic [WORD_W-1:0] hs_h [NH];
  logic [WORD_W-1:0] s_next;
  logic              sm_v;
  side_t             sm;
  logic [WORD_W-1:0] sm_sum;

  always_comb begin
    for (int h = 0; h < NH; h++) h_next[h] = '0;
    for (int i = 0; i < MC; i++) h_next[i >> 1] = h_next[i >> 1] + mu_p[i];
    s_next = '0;
    for (int h = 0; h < NH; h++) s_next = s_next + hs_h[h];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hs_v <= 1'b0;
      sm_v <= 1'b0;
    end else if (en) begin
      hs_v <= mu_v;
      sm_v <= hs_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hs <= mu;
      for (int h = 0; h < NH; h++) hs_h[h] <= h_next[h];
      sm     <= hs;
      sm_sum <= s_next;
    end
  end

  // Final action select into the output register.
  logic              fin_v;
  fin_t              fin;
  fin_t              fin_next;
  logic [WORD_W-1:0] sum_inc;

  assign sum_inc = sm_sum + WORD_W'(1);

  always_comb begin
    fin_next.action = sm.action;
    fin_next.lt     = sm.lt;
    fin_next.eq     = sm.eq;
    fin_next.dz     = sm.dz;
    case (sm.action)
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_NEG: fin_next.result = sm_sum;
      ACT_SUCC:    fin_next.result = (sum_inc == total_reg) ? '0 : sum_inc;
      ACT_PRED:    fin_next.result = (sm_sum == '0) ? total_reg - WORD_W'(1)
                                                    : sm_sum - WORD_W'(1);
      ACT_PROJECT: fin_next.result = WORD_W'(sm.pv);
      default:     fin_next.result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) fin_v <= 1'b0;
    else if (en) fin_v <= sm_v;
  end

  always_ff @(posedge clk) begin
    if (en) fin <= fin_next;
  end

  assign rsp.valid          = fin_v;
  assign rsp.result         = fin.result;
  assign rsp.divide_by_zero = fin.dz;
  assign rsp.left_less      = fin.lt;
  assign rsp.equal          = fin.eq;

  a_dz_only_divide: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.divide_by_zero |-> (fin.action == ACT_DIV || fin.action == ACT_MOD))
    else $error("divide_by_zero raised for an action that does not divide");

  a_wrap_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (fin.action == ACT_SUCC || fin.action == ACT_PRED)
      |-> rsp.result < total_reg)
    else $error("successor or predecessor left the range of the total size");

  a_compare_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.equal |-> !rsp.left_less)
    else $error("operands reported both equal and less");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (rst)
    sm_v && !en |=> sm_v && $stable(sm_sum))
    else $error("a stall changed a word inside the pipeline");

endmodule
`default_nettype wire
